[sv/motor_position_pd_pwm_defines.svh]
// Assertion macros shared by the motor position PD/PWM block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef MOTOR_POSITION_PD_PWM_DEFINES_SVH
`define MOTOR_POSITION_PD_PWM_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset.
`define MPP_ASSERT_NOW(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition leads to a consequence in the following cycle.
`define MPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MPP_ASSERT_NOW(label, clk, rst_n, prop, msg)
`define MPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/mpp_pkg.sv]
// Shared widths, register codes, reset values and control types of the
// motor position PD/PWM block. No dependencies.
package mpp_pkg;

    localparam int COUNT_W    = 32;
    localparam int CMD_W      = 13;
    localparam int BATT_W     = 15;
    localparam int DUTY_W     = 16;
    localparam int GAIN_W     = 32;
    localparam int SCALE_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ERR_W      = 56;
    localparam int VE_W       = 57;
    localparam int ACC_W      = 96;
    localparam int OPND_W     = 32;
    localparam int PROD_W     = 64;
    localparam int Q_FRAC     = 24;
    localparam int Q_OUT      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_EMF_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ENCODER = 3'd5;

    localparam logic [GAIN_W-1:0]  POSITION_GAIN_RESET = 32'd22282240;
    localparam logic [GAIN_W-1:0]  VELOCITY_GAIN_RESET = 32'd0;
    localparam logic [GAIN_W-1:0]  BACK_EMF_GAIN_RESET = 32'd23359980;
    localparam logic [SCALE_W-1:0] COMMAND_SCALE_RESET = 24'd29595;
    localparam logic [DUTY_W-1:0]  PWM_PERIOD_RESET    = 16'd1000;

    localparam logic [BATT_W-1:0] LOW_BATTERY_MV      = 15'd10000;
    localparam logic [BATT_W-1:0] FALLBACK_BATTERY_MV = 15'd18000;

    // Alignment of a product before it enters the accumulator.
    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_Q24,
        SHIFT_WORD
    } t_shift;

    typedef struct packed {
        logic   load;
        logic   mul;
        logic   acc;
        logic   neg;
        t_shift shift;
    } t_mac_ctl;

endpackage

[sv/mpp_in_if.sv]
// Input channel of the motor position PD/PWM block: one control tick.
// Depends on mpp_pkg for the field widths.
interface mpp_in_if import mpp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [COUNT_W-1:0]       encoder_count;
    logic signed [CMD_W-1:0]  speed_cmd_mm_s;
    logic [BATT_W-1:0]        battery_mv;

    modport source (output valid, encoder_count, speed_cmd_mm_s, battery_mv, input ready);
    modport sink (input valid, encoder_count, speed_cmd_mm_s, battery_mv, output ready);
endinterface

[sv/mpp_out_if.sv]
// Result channel of the motor position PD/PWM block: PWM compare values.
// Depends on mpp_pkg for the field widths.
interface mpp_out_if import mpp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [DUTY_W-1:0]         duty;
    logic                      forward;
    logic [DUTY_W-1:0]         compare_a;
    logic [DUTY_W-1:0]         compare_b;
    logic signed [COUNT_W-1:0] count_delta;

    modport source (output valid, duty, forward, compare_a, compare_b, count_delta,
                    input ready);
    modport sink (input valid, duty, forward, compare_a, compare_b, count_delta,
                  output ready);
endinterface

[sv/mpp_mac.sv]
// Shared 32x32 multiplier with a registered product and a 96-bit
// signed accumulator. Depends on mpp_pkg.
module mpp_mac import mpp_pkg::*; (
    input  logic              i_clk,
    input  t_mac_ctl          i_ctl,
    input  logic [OPND_W-1:0] i_a,
    input  logic [OPND_W-1:0] i_b,
    input  logic [ACC_W-1:0]  i_load_val,
    output logic [ACC_W-1:0]  o_acc,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    t_shift            r_shift;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  w_base;
    logic [ACC_W-1:0]  w_ext;
    logic [ACC_W-1:0]  w_term;

    always_comb begin
        w_base = ACC_W'(r_prod);
        case (r_shift)
            SHIFT_Q24:  w_ext = w_base << Q_FRAC;
            SHIFT_WORD: w_ext = w_base << OPND_W;
            default:    w_ext = w_base;
        endcase
        // Subtract by adding the one's complement plus one.
        w_term = w_ext ^ {ACC_W{r_neg}};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod  <= PROD_W'(i_a) * PROD_W'(i_b);
            r_neg   <= i_ctl.neg;
            r_shift <= i_ctl.shift;
        end
        if (i_ctl.load) begin
            r_acc <= i_load_val;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + w_term + ACC_W'(r_neg);
        end
    end

    assign o_acc  = r_acc;
    assign o_prod = r_prod;

endmodule

[sv/mpp_div.sv]
// Restoring divider, one quotient bit per cycle, for the duty scaling.
// Depends on mpp_pkg and motor_position_pd_pwm_defines.svh.
`include "motor_position_pd_pwm_defines.svh"

module mpp_div import mpp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*DUTY_W-1:0]   i_num,
    input  logic [BATT_W-1:0]     i_den,
    output logic                  o_busy,
    output logic [DUTY_W-1:0]     o_quot
);

    localparam int CNT_W = $clog2(DUTY_W + 1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [BATT_W-1:0]   r_rem;
    logic [DUTY_W-1:0]   r_quot;
    logic [BATT_W:0]     w_trial;
    logic [BATT_W:0]     w_diff;
    logic                w_ge;

    always_comb begin
        w_trial = {r_rem, r_quot[DUTY_W-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = (w_trial >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DUTY_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient fits the low half: seed the remainder with the high half.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[DUTY_W +: BATT_W];
            r_quot <= i_num[DUTY_W-1:0];
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[BATT_W-1:0] : w_trial[BATT_W-1:0];
            r_quot <= {r_quot[DUTY_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

    `MPP_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "divider restarted while busy")
    `MPP_ASSERT_NOW(a_rem_below_den, i_clk, i_rst_n, r_busy |-> (r_rem < i_den), "remainder not below divisor")
    `MPP_ASSERT_NEXT(a_start_loads, i_clk, i_rst_n, i_start, r_busy && (r_cnt == CNT_W'(DUTY_W)), "divider did not load")

endmodule

[sv/motor_position_pd_pwm.sv]
// Top level of the motor position PD/PWM block: register file, sequencer,
// shared multiply-accumulate and duty divider.
// Depends on mpp_pkg, mpp_in_if, mpp_out_if, mpp_mac, mpp_div and the defines header.
//
//  channel   direction  handshake        payload
//  i_in      sink       valid / ready    encoder_count, speed_cmd_mm_s, battery_mv
//  o_out     source     valid / ready    duty, forward, compare_a, compare_b, count_delta
//  i_cfg_*   write      i_cfg_we         i_cfg_idx selects register, i_cfg_data value
//
// From acceptance until the result shows and input ready returns, a transaction runs
// seven products on one shared 32x32 multiplier (a multiply state, then an accumulate
// state, for each control-law product) and 16 quotient-bit steps of the duty divider.
// Input ready is high only while the sequencer is idle; a stalled sink holds the
// result in the output register and the next one in the sequencer's last state.
// Synchronous active-low reset clears the sequencer and loop state, presets registers.
`include "motor_position_pd_pwm_defines.svh"

module motor_position_pd_pwm import mpp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mpp_in_if.sink                i_in,
    mpp_out_if.source             o_out
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_ACC    = 4'd2;
    localparam logic [3:0] S_PE     = 4'd3;
    localparam logic [3:0] S_MAG    = 4'd4;
    localparam logic [3:0] S_ABS    = 4'd5;
    localparam logic [3:0] S_CLAMP  = 4'd6;
    localparam logic [3:0] S_DIV_GO = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    // Products run through the shared multiplier, in order.
    localparam logic [2:0] STEP_CMD   = 3'd0;
    localparam logic [2:0] STEP_PE_LO = 3'd1;
    localparam logic [2:0] STEP_PE_HI = 3'd2;
    localparam logic [2:0] STEP_VE_LO = 3'd3;
    localparam logic [2:0] STEP_VE_HI = 3'd4;
    localparam logic [2:0] STEP_BEMF  = 3'd5;
    localparam logic [2:0] STEP_DUTY  = 3'd6;

    // Configuration registers.
    logic [GAIN_W-1:0]  r_position_gain;
    logic [GAIN_W-1:0]  r_velocity_gain;
    logic [GAIN_W-1:0]  r_back_emf_gain;
    logic [SCALE_W-1:0] r_command_scale;
    logic [DUTY_W-1:0]  r_pwm_period;
    logic               r_invert_encoder;

    // Sequencer.
    logic [3:0] r_state, n_state;
    logic [2:0] r_step, n_step;

    // Loop state and per-transaction working registers.
    logic [COUNT_W-1:0] r_prev;
    logic [ERR_W-1:0]   r_pos_err;
    logic [COUNT_W-1:0] r_delta;
    logic [CMD_W-1:0]   r_cmd_mag;
    logic               r_cmd_neg;
    logic [BATT_W-1:0]  r_batt;
    logic [VE_W-1:0]    r_ve;
    logic [ERR_W-1:0]   r_pe_mag;
    logic [VE_W-1:0]    r_ve_mag;
    logic [COUNT_W-1:0] r_dlt_mag;
    logic               r_fwd;
    logic [ACC_W-Q_OUT-1:0] r_abs_hi;
    logic [BATT_W-1:0]  r_mag;

    // Output register.
    logic               r_out_valid;
    logic [DUTY_W-1:0]  r_out_duty;
    logic               r_out_fwd;
    logic [COUNT_W-1:0] r_out_delta;

    // Datapath wires.
    logic                w_in_acc;
    logic                w_out_load;
    logic [COUNT_W-1:0]  w_cur;
    logic [COUNT_W-1:0]  w_dbits;
    logic [CMD_W-1:0]    w_cmd;
    logic [VE_W-1:0]     w_ve;
    logic [ERR_W+1:0]    w_pe_sum;
    logic [ERR_W-1:0]    w_pe_sat;
    logic [ACC_W-1:0]    w_abs;
    t_mac_ctl            w_mac_ctl;
    logic [OPND_W-1:0]   w_mac_a;
    logic [OPND_W-1:0]   w_mac_b;
    logic [ACC_W-1:0]    w_load_val;
    logic [ACC_W-1:0]    w_acc;
    logic [PROD_W-1:0]   w_prod;
    logic                w_div_start;
    logic                w_div_busy;
    logic [DUTY_W-1:0]   w_quot;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_gain  <= POSITION_GAIN_RESET;
            r_velocity_gain  <= VELOCITY_GAIN_RESET;
            r_back_emf_gain  <= BACK_EMF_GAIN_RESET;
            r_command_scale  <= COMMAND_SCALE_RESET;
            r_pwm_period     <= PWM_PERIOD_RESET;
            r_invert_encoder <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POSITION_GAIN:  r_position_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_VELOCITY_GAIN:  r_velocity_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_BACK_EMF_GAIN:  r_back_emf_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_COMMAND_SCALE:  r_command_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_PWM_PERIOD:     r_pwm_period     <= i_cfg_data[DUTY_W-1:0];
                CFG_INVERT_ENCODER: r_invert_encoder <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_MUL;
                    n_step  = STEP_CMD;
                end
            end
            S_MUL: begin
                n_state = (r_step == STEP_DUTY) ? S_DIV_GO : S_ACC;
            end
            S_ACC: begin
                if (r_step == STEP_CMD) begin
                    n_state = S_PE;
                end else if (r_step == STEP_BEMF) begin
                    n_state = S_ABS;
                end else begin
                    n_state = S_MUL;
                    n_step  = r_step + 3'd1;
                end
            end
            S_PE:     n_state = S_MAG;
            S_MAG: begin
                n_state = S_MUL;
                n_step  = STEP_PE_LO;
            end
            S_ABS:    n_state = S_CLAMP;
            S_CLAMP: begin
                n_state = S_MUL;
                n_step  = STEP_DUTY;
            end
            S_DIV_GO: n_state = S_DIV;
            S_DIV: begin
                if (!w_div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_CMD;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Encoder delta and command magnitude at acceptance.
    always_comb begin
        w_cur   = r_invert_encoder ? (~i_in.encoder_count + COUNT_W'(1)) : i_in.encoder_count;
        w_dbits = w_cur - r_prev;
        w_cmd   = i_in.speed_cmd_mm_s;
    end

    // Position error: velocity error sits in the low bits of the accumulator.
    always_comb begin
        w_ve     = w_acc[VE_W-1:0];
        w_pe_sum = {{2{r_pos_err[ERR_W-1]}}, r_pos_err} + {w_ve[VE_W-1], w_ve};
        if (w_pe_sum[ERR_W+1:ERR_W-1] == 3'b000 || w_pe_sum[ERR_W+1:ERR_W-1] == 3'b111) begin
            w_pe_sat = w_pe_sum[ERR_W-1:0];
        end else if (w_pe_sum[ERR_W+1]) begin
            w_pe_sat = {1'b1, {(ERR_W-1){1'b0}}};
        end else begin
            w_pe_sat = {1'b0, {(ERR_W-1){1'b1}}};
        end
        w_abs = w_acc[ACC_W-1] ? (~w_acc + ACC_W'(1)) : w_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_pos_err <= '0;
        end else begin
            if (w_in_acc) begin
                r_prev <= w_cur;
            end
            if (r_state == S_PE) begin
                r_pos_err <= w_pe_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_delta   <= w_dbits;
            r_cmd_neg <= w_cmd[CMD_W-1];
            r_cmd_mag <= w_cmd[CMD_W-1] ? (~w_cmd + CMD_W'(1)) : w_cmd;
            r_batt    <= (i_in.battery_mv < LOW_BATTERY_MV) ? FALLBACK_BATTERY_MV
                                                            : i_in.battery_mv;
        end
        if (r_state == S_PE) begin
            r_ve <= w_ve;
        end
        // Magnitudes feed the unsigned multiplier; signs go to the accumulator.
        if (r_state == S_MAG) begin
            r_pe_mag  <= r_pos_err[ERR_W-1] ? (~r_pos_err + ERR_W'(1)) : r_pos_err;
            r_ve_mag  <= r_ve[VE_W-1] ? (~r_ve + VE_W'(1)) : r_ve;
            r_dlt_mag <= r_delta[COUNT_W-1] ? (~r_delta + COUNT_W'(1)) : r_delta;
        end
        if (r_state == S_ABS) begin
            r_fwd    <= !w_acc[ACC_W-1] && (w_acc != '0);
            r_abs_hi <= w_abs[ACC_W-1:Q_OUT];
        end
        // Clamp the drive magnitude to the battery.
        if (r_state == S_CLAMP) begin
            r_mag <= (r_abs_hi > (ACC_W-Q_OUT)'(r_batt)) ? r_batt : r_abs_hi[BATT_W-1:0];
        end
    end

    // Operand select for the shared multiplier.
    always_comb begin
        w_mac_a         = '0;
        w_mac_b         = '0;
        w_mac_ctl.neg   = 1'b0;
        w_mac_ctl.shift = SHIFT_NONE;
        case (r_step)
            STEP_CMD: begin
                w_mac_a       = OPND_W'(r_cmd_mag);
                w_mac_b       = OPND_W'(r_command_scale);
                w_mac_ctl.neg = !r_cmd_neg;
            end
            STEP_PE_LO: begin
                w_mac_a       = r_pe_mag[OPND_W-1:0];
                w_mac_b       = r_position_gain;
                w_mac_ctl.neg = !r_pos_err[ERR_W-1];
            end
            STEP_PE_HI: begin
                w_mac_a         = OPND_W'(r_pe_mag[ERR_W-1:OPND_W]);
                w_mac_b         = r_position_gain;
                w_mac_ctl.neg   = !r_pos_err[ERR_W-1];
                w_mac_ctl.shift = SHIFT_WORD;
            end
            STEP_VE_LO: begin
                w_mac_a       = r_ve_mag[OPND_W-1:0];
                w_mac_b       = r_velocity_gain;
                w_mac_ctl.neg = !r_ve[VE_W-1];
            end
            STEP_VE_HI: begin
                w_mac_a         = OPND_W'(r_ve_mag[VE_W-1:OPND_W]);
                w_mac_b         = r_velocity_gain;
                w_mac_ctl.neg   = !r_ve[VE_W-1];
                w_mac_ctl.shift = SHIFT_WORD;
            end
            STEP_BEMF: begin
                w_mac_a         = r_dlt_mag;
                w_mac_b         = r_back_emf_gain;
                w_mac_ctl.neg   = r_delta[COUNT_W-1];
                w_mac_ctl.shift = SHIFT_Q24;
            end
            STEP_DUTY: begin
                w_mac_a = OPND_W'(r_pwm_period);
                w_mac_b = OPND_W'(r_mag);
            end
            default: ;
        endcase
        w_mac_ctl.mul  = (r_state == S_MUL);
        w_mac_ctl.acc  = (r_state == S_ACC);
        // Seed with delta in Q24 for the velocity error, clear before the control law.
        w_mac_ctl.load = (r_state == S_MAG) || (r_state == S_MUL && r_step == STEP_CMD);
        w_load_val     = (r_state == S_MAG) ? '0
                       : {{(ACC_W-COUNT_W-Q_FRAC){r_delta[COUNT_W-1]}}, r_delta,
                          {Q_FRAC{1'b0}}};
    end

    mpp_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (w_mac_ctl),
        .i_a        (w_mac_a),
        .i_b        (w_mac_b),
        .i_load_val (w_load_val),
        .o_acc      (w_acc),
        .o_prod     (w_prod)
    );

    assign w_div_start = (r_state == S_DIV_GO);

    mpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod[2*DUTY_W-1:0]),
        .i_den   (r_batt),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Hold the result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_duty  <= w_quot;
            r_out_fwd   <= r_fwd;
            r_out_delta <= r_delta;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.duty        = r_out_duty;
    assign o_out.forward     = r_out_fwd;
    assign o_out.compare_a   = r_out_fwd ? r_out_duty : '0;
    assign o_out.compare_b   = r_out_fwd ? '0 : r_out_duty;
    assign o_out.count_delta = r_out_delta;

    `MPP_ASSERT_NOW(a_duty_in_range, i_clk, i_rst_n, r_out_valid |-> (r_out_duty <= r_pwm_period), "duty above period")
    `MPP_ASSERT_NOW(a_mag_clamped, i_clk, i_rst_n, (r_state == S_MUL && r_step == STEP_DUTY) |-> (r_mag <= r_batt), "magnitude above battery")
    `MPP_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_in_acc, r_state == S_MUL && r_step == STEP_CMD && !i_in.ready, "accept did not start sequence")

endmodule
